// File: hdl/luwt_pkg.sv
// ----------------------------------------------------------------------------
// luwt_pkg
// Shared widths for the longest unique window tracker.
// ----------------------------------------------------------------------------
package luwt_pkg;

    // width of one input byte
    localparam int SYMBOL_W = 8;

    // width of the reported window and best lengths
    localparam int LEN_W = 17;

endpackage

// File: hdl/longest_unique_window_tracker.sv
// ----------------------------------------------------------------------------
// longest_unique_window_tracker
// Streams a string one byte per word and reports the length of the
// repeat-free window ending at each byte and the best length so far.
// ----------------------------------------------------------------------------
// The block takes one byte every clock cycle while the output side does not
// stall and returns one result word per byte, registered through stage one
// and the output register; an output stall holds the input back only once
// both the result register and the stage behind it are full.
// The rate is set by one read and one write per byte of the last-position
// memory (ALPHABET_SIZE entries, registered read); a byte that directly
// follows a byte of the same symbol gets the fresh position through
// a forwarding register. Seen marks sit in flip-flops so that the byte flagged
// end_of_string clears them, the counters and the overflow flag at once; the
// next string may start in the very next cycle. Counters saturate after
// MAX_STRING_LENGTH bytes and raise overflow until the string ends.
module longest_unique_window_tracker
    import luwt_pkg::*;
#(
    parameter int ALPHABET_SIZE     = 256,
    parameter int MAX_STRING_LENGTH = 65536
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SYMBOL_W-1:0] symbol,
    input  logic                end_of_string,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LEN_W-1:0]    window_length,
    output logic [LEN_W-1:0]    best_length,
    output logic                final_result,
    output logic                overflow
);

    localparam int SYM_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int PW    = $clog2(MAX_STRING_LENGTH);
    localparam int CW    = PW + 1;

    // reciprocal of the alphabet size, exact quotient for any byte
    localparam int RECIP_SH = 2 * SYMBOL_W;
    localparam logic [RECIP_SH:0] RECIP =
        (RECIP_SH+1)'(((1 << RECIP_SH) + ALPHABET_SIZE - 1) / ALPHABET_SIZE);

    // reduce a byte modulo the alphabet size by reciprocal multiplication
    function automatic logic [SYM_W-1:0] reduce_symbol(input logic [SYMBOL_W-1:0] s);
        logic [SYMBOL_W+RECIP_SH:0] prod;
        logic [SYMBOL_W-1:0]        quot;
        logic [RECIP_SH:0]          qa;
        logic [SYMBOL_W-1:0]        rem;
        prod = {{(RECIP_SH+1){1'b0}}, s} * {{SYMBOL_W{1'b0}}, RECIP};
        quot = prod[RECIP_SH +: SYMBOL_W];
        qa   = {{(SYMBOL_W+1){1'b0}}, quot} * (RECIP_SH+1)'(ALPHABET_SIZE);
        rem  = s - qa[SYMBOL_W-1:0];
        return rem[SYM_W-1:0];
    endfunction

    // last-position memory
    logic [PW-1:0] last_pos_mem [ALPHABET_SIZE];
    logic [PW-1:0] rd_data_reg;

    // stage one: word waiting for the memory data
    logic             s1_valid_reg;
    logic [SYM_W-1:0] s1_sym_reg;
    logic             s1_last_reg;
    logic             fwd_hit_reg;
    logic [PW-1:0]    fwd_data_reg;

    // running state
    logic [ALPHABET_SIZE-1:0] seen_reg;
    logic [CW-1:0]            pos_count_reg;
    logic [PW-1:0]            window_start_reg;
    logic [CW-1:0]            best_reg;
    logic                     ovf_reg;

    // output word
    logic             out_valid_reg;
    logic [LEN_W-1:0] wlen_out_reg;
    logic [LEN_W-1:0] best_out_reg;
    logic             final_out_reg;
    logic             ovf_out_reg;

    logic             in_fire;
    logic             s1_fire;
    logic [SYM_W-1:0] in_sym;
    logic             ovf_now;
    logic [PW-1:0]    lp;
    logic             hit;
    logic [PW-1:0]    window_start_next;
    logic [CW-1:0]    wlen;
    logic [CW-1:0]    best_next;
    logic             mem_we;

    // handshake
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;
    assign in_sym   = reduce_symbol(symbol);

    // window update for the word in stage one
    always_comb
    begin
        ovf_now           = pos_count_reg >= CW'(MAX_STRING_LENGTH);
        lp                = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        hit               = seen_reg[s1_sym_reg] && (lp >= window_start_reg);
        window_start_next = window_start_reg;
        best_next         = best_reg;
        if (ovf_now)
        begin
            wlen = pos_count_reg - CW'(window_start_reg);
        end
        else
        begin
            if (hit)
            begin
                window_start_next = lp + PW'(1);
            end
            wlen = pos_count_reg - CW'(window_start_next) + CW'(1);
            if (wlen > best_reg)
            begin
                best_next = wlen;
            end
        end
        mem_we = s1_fire && !ovf_now;
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            last_pos_mem[s1_sym_reg] <= pos_count_reg[PW-1:0];
        end
        if (in_fire)
        begin
            rd_data_reg <= last_pos_mem[in_sym];
        end
    end

    // stage one payload and forwarding of a same-cycle write
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sym_reg   <= in_sym;
            s1_last_reg  <= end_of_string;
            fwd_hit_reg  <= mem_we && (s1_sym_reg == in_sym);
            fwd_data_reg <= pos_count_reg[PW-1:0];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            wlen_out_reg  <= LEN_W'(wlen);
            best_out_reg  <= LEN_W'(best_next);
            final_out_reg <= s1_last_reg;
            ovf_out_reg   <= ovf_reg || ovf_now;
        end
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            seen_reg         <= '0;
            pos_count_reg    <= '0;
            window_start_reg <= '0;
            best_reg         <= '0;
            ovf_reg          <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                if (s1_last_reg)
                begin
                    seen_reg         <= '0;
                    pos_count_reg    <= '0;
                    window_start_reg <= '0;
                    best_reg         <= '0;
                    ovf_reg          <= 1'b0;
                end
                else if (ovf_now)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    seen_reg[s1_sym_reg] <= 1'b1;
                    pos_count_reg        <= pos_count_reg + CW'(1);
                    window_start_reg     <= window_start_next;
                    best_reg             <= best_next;
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_length = wlen_out_reg;
    assign best_length   = best_out_reg;
    assign final_result  = final_out_reg;
    assign overflow      = ovf_out_reg;

endmodule
